[rtl/cbf_pkg.sv]
package cbf_pkg;

  localparam int DEF_MAX_CELLS = 4096;
  localparam int DEF_COUNTER_BITS = 4;
  localparam int DEF_NUM_HASHES = 4;
  localparam int DIGEST_FIELDS = 4;
  localparam int DIGEST_W = 64;
  localparam int CELLS_CFG_W = 13;
  localparam int HASHES_CFG_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_DEC   = 2'd1,
    ACT_COUNT = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  localparam logic REG_CELLS = 1'b0;
  localparam logic REG_HASHES = 1'b1;

endpackage

[rtl/counting_bloom_filter_core.sv]
// Channel  Dir  Signals                          Payload
// s_axis   in   s_axis_tvalid/tready/tdata       action, digest_0..digest_3
// m_axis   out  m_axis_tvalid/tready/tdata       min_count, done_res
// cfg      in   cfg_valid/ready/index/data       cells_in_use, hashes_in_use
// An item is first reduced modulo the cell count (four bits a cycle, one lane per
// digest), then read at each used digest and, for add or a decrement that
// succeeds, written back over the single counter memory. Clear sweeps the store,
// one cell a cycle. After reset a clearing pass over all MAX_CELLS cells runs
// before the first word is taken. A stalled result register holds off the next word.
module counting_bloom_filter_core import cbf_pkg::*; #(
  parameter int MAX_CELLS = DEF_MAX_CELLS,
  parameter int COUNTER_BITS = DEF_COUNTER_BITS,
  parameter int NUM_HASHES = DEF_NUM_HASHES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [263:0] s_axis_tdata,  // action[1:0], digest_0..digest_3 [65:2]..[257:194]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // min_count[3:0], done_res[4]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int NL = (NUM_HASHES < DIGEST_FIELDS) ? NUM_HASHES : DIGEST_FIELDS;
  localparam int HW = $clog2(NL + 1);
  localparam int LW = (NL > 1) ? $clog2(NL) : 1;
  localparam logic [COUNTER_BITS-1:0] CMAX = '1;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_RD    = 7'b0001000,
    S_RDW   = 7'b0010000,
    S_WR    = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [CELLS_CFG_W-1:0]  cells_in_use;
  logic [HASHES_CFG_W-1:0] hashes_in_use;
  logic [AW:0]             cells_eff;
  logic [HW-1:0]           nh;
  logic [1:0]              action;
  logic [AW:0]             sweep;
  logic [HW-1:0]           idx;
  logic                    wr_phase;
  logic [COUNTER_BITS-1:0] minv;
  logic                    lane_start;
  logic [NL-1:0]           lane_busy;
  logic [AW-1:0]           lane_addr [NL];
  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic [COUNTER_BITS-1:0] wdata, rdata;
  logic [3:0]              out_min;
  logic                    out_done;
  logic                    out_load;

  always_comb begin
    if (cells_in_use == '0) cells_eff = (AW+1)'(1);
    else if ({{32-CELLS_CFG_W{1'b0}}, cells_in_use} > MAX_CELLS) cells_eff = (AW+1)'(MAX_CELLS);
    else cells_eff = (AW+1)'(cells_in_use);
    if (hashes_in_use == '0) nh = HW'(1);
    else if (32'(hashes_in_use) > NL) nh = HW'(NL);
    else nh = HW'(hashes_in_use);
  end

  assign lane_start = s_axis_tvalid && s_axis_tready;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    cbf_mod_lane #(.MAX_CELLS(MAX_CELLS)) u_lane (
      .clk(clk), .start(lane_start),
      .digest(s_axis_tdata[2 + g*DIGEST_W +: DIGEST_W]),
      .cells(cells_eff), .busy(lane_busy[g]), .addr(lane_addr[g])
    );
  end

  assign raddr = lane_addr[idx[LW-1:0]];

  // In S_WR the read data belongs to the addressed cell once wr_phase is set;
  // counters are updated one digest after another, so a repeated cell sees the earlier write.
  always_comb begin
    we = 1'b0;
    waddr = raddr;
    wdata = rdata;
    if (state == S_INIT) begin
      we = 1'b1;
      waddr = sweep[AW-1:0];
      wdata = '0;
    end else if (state == S_WR && wr_phase) begin
      we = 1'b1;
      if (action == ACT_ADD) wdata = (rdata == CMAX) ? rdata : rdata + 1'b1;
      else wdata = (rdata == '0) ? rdata : rdata - 1'b1;
    end
  end

  cbf_ram #(.WIDTH(COUNTER_BITS), .DEPTH(MAX_CELLS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign s_axis_tready = (state == S_IDLE) && !cfg_valid && (!m_axis_tvalid || m_axis_tready);
  assign cfg_ready = (state == S_IDLE);

  assign out_load = (lane_start && s_axis_tdata[1:0] == ACT_CLEAR) ||
                    (state == S_OUT && (!m_axis_tvalid || m_axis_tready));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      sweep <= '0;
      cells_in_use <= CELLS_CFG_W'(4096);
      hashes_in_use <= HASHES_CFG_W'(4);
      m_axis_tvalid <= 1'b0;
      idx <= '0;
      wr_phase <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CELLS) cells_in_use <= cfg_data[CELLS_CFG_W-1:0];
        else hashes_in_use <= cfg_data[HASHES_CFG_W-1:0];
      end
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == (AW+1)'(MAX_CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (lane_start) begin
            action <= s_axis_tdata[1:0];
            minv <= CMAX;
            idx <= '0;
            if (s_axis_tdata[1:0] == ACT_CLEAR) begin
              sweep <= '0;
              state <= S_INIT;
              out_min <= '0;
              out_done <= 1'b1;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (lane_busy == '0) state <= S_RD;
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          if (rdata < minv) minv <= rdata;
          if (idx == nh - 1'b1) begin
            idx <= '0;
            state <= S_OUT;
          end else begin
            idx <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_min <= 4'(minv);
            if (action == ACT_ADD) out_done <= 1'b1;
            else out_done <= (minv != '0);
            if (action == ACT_ADD || (action == ACT_DEC && minv != '0)) begin
              wr_phase <= 1'b0;
              state <= S_WR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_WR: begin
          wr_phase <= !wr_phase;
          if (wr_phase) begin
            if (idx == nh - 1'b1) state <= S_IDLE;
            else idx <= idx + 1'b1;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  assign m_axis_tdata = {3'b000, out_done, out_min};

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == S_IDLE) else $error("ready outside idle");
  a_init_noready: assert property (@(posedge clk) disable iff (rst)
    state == S_INIT |-> !s_axis_tready) else $error("ready during clear");
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_INIT || state == S_WR)) else $error("stray write");

endmodule

[rtl/cbf_ram.sv]
module cbf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cbf_mod_lane.sv]
module cbf_mod_lane import cbf_pkg::*; #(
  parameter int MAX_CELLS = DEF_MAX_CELLS
) (
  input  logic                         clk,
  input  logic                         start,
  input  logic [DIGEST_W-1:0]          digest,
  input  logic [$clog2(MAX_CELLS):0]   cells,
  output logic                         busy,
  output logic [$clog2(MAX_CELLS)-1:0] addr
);

  localparam int CW = $clog2(MAX_CELLS) + 1;
  localparam int STEPS_PER = 4;
  localparam int CNT_W = $clog2(DIGEST_W / STEPS_PER + 1);

  logic [DIGEST_W-1:0] shreg;
  logic [CW:0]         rem;
  logic [CNT_W-1:0]    cnt;
  logic [CW:0]         r_next;
  logic [DIGEST_W-1:0] s_next;

  always_comb begin
    logic [CW:0] t;
    r_next = rem;
    s_next = shreg;
    for (int k = 0; k < STEPS_PER; k++) begin
      t = {r_next[CW-1:0], s_next[DIGEST_W-1]};
      s_next = {s_next[DIGEST_W-2:0], 1'b0};
      if (t >= {1'b0, cells}) begin
        t = t - {1'b0, cells};
      end
      r_next = t;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= digest;
      rem <= '0;
      cnt <= CNT_W'(DIGEST_W / STEPS_PER);
    end else if (cnt != '0) begin
      shreg <= s_next;
      rem <= r_next;
      cnt <= cnt - 1'b1;
    end
  end

  assign busy = (cnt != '0);
  assign addr = rem[CW-2:0];

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench import cbf_pkg::*;;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int POOL_KEYS = 8;

  class bloom_scoreboard;
    bit [3:0] counters [DEF_MAX_CELLS];
    int unsigned cells_reg;
    int unsigned hashes_reg;
    bit [4:0] pending_results [$];
    int errors;

    function new();
      foreach (counters[i]) counters[i] = 4'd0;
      cells_reg = 4096;
      hashes_reg = 4;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_CELLS) cells_reg = value[CELLS_CFG_W-1:0];
      else hashes_reg = value[HASHES_CFG_W-1:0];
    endfunction

    function void note_input(action_t act, logic [63:0] dig [4]);
      int unsigned ncells;
      int unsigned nh;
      int unsigned addr [4];
      bit [3:0] minv;
      bit done;
      ncells = (cells_reg == 0) ? 1 : (cells_reg > DEF_MAX_CELLS ? DEF_MAX_CELLS : cells_reg);
      nh = (hashes_reg == 0) ? 1 : (hashes_reg > DEF_NUM_HASHES ? DEF_NUM_HASHES : hashes_reg);
      minv = 4'hF;
      done = 1'b1;
      if (act == ACT_CLEAR) begin
        foreach (counters[i]) counters[i] = 4'd0;
        pending_results.push_back({1'b1, 4'd0});
        return;
      end
      for (int i = 0; i < nh; i++) begin
        addr[i] = 32'(dig[i] % 64'(ncells));
        if (counters[addr[i]] < minv) minv = counters[addr[i]];
      end
      case (act)
        ACT_ADD: begin
          for (int i = 0; i < nh; i++)
            if (counters[addr[i]] != 4'hF) counters[addr[i]]++;
        end
        ACT_DEC: begin
          done = (minv != 0);
          if (done)
            for (int i = 0; i < nh; i++)
              if (counters[addr[i]] != 0) counters[addr[i]]--;
        end
        default: done = (minv != 0);
      endcase
      pending_results.push_back({done, minv});
    endfunction

    function void check_result(logic [7:0] word);
      bit [4:0] want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, word);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (word[3:0] !== want[3:0]) begin
        $display("%0t: min_count expected %0d actual %0d", $time, want[3:0], word[3:0]);
        errors++;
      end
      if (word[4] !== want[4]) begin
        $display("%0t: done_res expected %0d actual %0d", $time, want[4], word[4]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [263:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bloom_scoreboard sb = new();
  int cycles = 0;
  bit quiet = 1'b0;
  logic [63:0] key_pool [POOL_KEYS][4];

  counting_bloom_filter_core DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    int run;
    int stall;
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 20);
      stall = pick_gap();
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_item(action_t act, logic [63:0] d0, logic [63:0] d1,
                           logic [63:0] d2, logic [63:0] d3);
    int gap;
    logic [63:0] dig [4];
    gap = pick_gap();
    dig = '{d0, d1, d2, d3};
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, d3, d2, d1, d0, act};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(act, dig);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_item();
    int r;
    int k;
    action_t act;
    r = $urandom_range(0, 99);
    act = r < 40 ? ACT_ADD : (r < 65 ? ACT_DEC : (r < 98 ? ACT_COUNT : ACT_CLEAR));
    if ($urandom_range(0, 99) < 85) begin
      k = $urandom_range(0, POOL_KEYS - 1);
      send_item(act, key_pool[k][0], key_pool[k][1], key_pool[k][2], key_pool[k][3]);
    end else begin
      send_item(action_t'($urandom_range(0, 2)), rand64(), rand64(),
                $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : rand64(),
                $urandom_range(0, 1) ? 64'd0 : rand64());
    end
  endtask

  initial begin
    logic [12:0] cell_set [8];
    logic [2:0] hash_set [8];
    logic [63:0] ones;
    cell_set = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd5, 13'd16, 13'd4095, 13'd3};
    hash_set = '{3'd4, 3'd1, 3'd7, 3'd0, 3'd3, 3'd2, 3'd4, 3'd5};
    ones = 64'hFFFF_FFFF_FFFF_FFFF;
    foreach (key_pool[i, j]) key_pool[i][j] = rand64();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    quiet = 1'b1;
    send_item(ACT_COUNT, 0, 0, 0, 0);
    send_item(ACT_DEC, 0, 0, 0, 0);
    send_item(ACT_ADD, 0, 0, 0, 0);
    send_item(ACT_COUNT, 0, 0, 0, 0);
    quiet = 1'b0;
    send_item(ACT_ADD, ones, ones, ones, ones);
    send_item(ACT_COUNT, ones, ones, ones, ones);
    send_item(ACT_COUNT, rand64(), rand64(), rand64(), rand64());
    send_item(ACT_DEC, 0, 0, 0, 0);
    send_item(ACT_CLEAR, ones, 0, ones, 0);
    send_item(ACT_COUNT, ones, ones, ones, ones);
    settle();
    write_reg(REG_CELLS, 16'd1);
    repeat (5) send_item(ACT_ADD, rand64(), rand64(), rand64(), rand64());
    send_item(ACT_COUNT, ones, 0, ones, 0);
    repeat (4) send_item(ACT_DEC, rand64(), rand64(), rand64(), rand64());
    send_item(ACT_COUNT, 0, 0, 0, 0);
    send_item(ACT_CLEAR, 0, 0, 0, 0);
    send_item(ACT_DEC, 0, 0, 0, 0);
    settle();

    for (int p = 0; p < 16; p++) begin
      write_reg(REG_CELLS, {3'($urandom_range(0, 7)), cell_set[p % 8]});
      write_reg(REG_HASHES, {13'($urandom), hash_set[(p * 3) % 8]});
      quiet = (p % 5 == 2);
      repeat (25) random_item();
      settle();
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
